// ----- rtl/hlcd_pkg.sv -----
// shared constants, codes and the queue record type for the frame receiver
`timescale 1ns / 1ps

package hlcd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned OFFSET_W    = 16;
   localparam int unsigned LENGTH_W    = 16;
   localparam int unsigned POS_W       = 17;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [POS_W-1:0] HEADER_BYTES = 17'd6;

   localparam logic [BYTE_W-1:0] START_FIRST_RESET  = 8'h55;
   localparam logic [BYTE_W-1:0] START_SECOND_RESET = 8'hAA;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FIRST  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SECOND = 1'b1;

   // byte positions within a frame
   localparam logic [POS_W-1:0] POS_HUNT    = 17'd0;
   localparam logic [POS_W-1:0] POS_SECOND  = 17'd1;
   localparam logic [POS_W-1:0] POS_VERSION = 17'd2;
   localparam logic [POS_W-1:0] POS_COMMAND = 17'd3;
   localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd4;
   localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd5;

   // classification of a received byte
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [BYTE_W-1:0]   data;
      logic [BYTE_W-1:0]   sum;
      logic [OFFSET_W-1:0] offset;
      logic [BYTE_W-1:0]   version;
      logic [BYTE_W-1:0]   command;
      logic [LENGTH_W-1:0] length;
   } rec_type;

endpackage

// ----- rtl/hlcd_req_if.sv -----
// byte input channel and result channel interfaces
`timescale 1ns / 1ps

interface hlcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic [15:0] payload_offset;
   logic        frame_done;
   logic        checksum_ok;
   logic [7:0]  frame_version;
   logic [7:0]  frame_command;
   logic [15:0] frame_length;

   modport source (output valid, output payload_valid, output payload_byte,
                   output payload_offset, output frame_done, output checksum_ok,
                   output frame_version, output frame_command, output frame_length,
                   input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input payload_offset, input frame_done, input checksum_ok,
                   input frame_version, input frame_command, input frame_length,
                   output ready);
endinterface

// ----- rtl/hlcd_front.sv -----
// front end: start byte hunt, header capture, running sum and byte classification
`timescale 1ns / 1ps

module hlcd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [hlcd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hlcd_pkg::BYTE_W-1:0]         csr_wr_data,
   hlcd_req_if.sink                            req_chan,
   input  logic                                push_ready,
   output logic                                push_valid,
   output hlcd_pkg::rec_type                   push_rec
);

   logic [hlcd_pkg::BYTE_W-1:0]   start_first_ff, start_second_ff;
   logic [hlcd_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [hlcd_pkg::BYTE_W-1:0]   sum_ff, sum_in;
   logic [hlcd_pkg::BYTE_W-1:0]   version_ff, version_in;
   logic [hlcd_pkg::BYTE_W-1:0]   command_ff, command_in;
   logic [hlcd_pkg::BYTE_W-1:0]   len_hi_ff, len_hi_in;
   logic [hlcd_pkg::LENGTH_W-1:0] len_ff, len_in;
   logic                          len_known_ff, len_known_in;
   logic                          accept;
   logic                          advance;
   logic                          hunt;
   logic [hlcd_pkg::BYTE_W-1:0]   b;
   logic [hlcd_pkg::POS_W-1:0]    end_pos;
   logic [hlcd_pkg::POS_W-1:0]    offset_full;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign push_valid     = req_chan.valid;
   assign b              = req_chan.rx_byte;
   assign end_pos        = hlcd_pkg::HEADER_BYTES + {1'b0, len_ff};
   assign offset_full    = pos_ff - hlcd_pkg::HEADER_BYTES;

   always_comb begin
      push_rec         = '0;
      push_rec.kind    = hlcd_pkg::KIND_NONE;
      push_rec.data    = b;
      push_rec.sum     = sum_ff;
      push_rec.offset  = offset_full[hlcd_pkg::OFFSET_W-1:0];
      push_rec.version = version_ff;
      push_rec.command = command_ff;
      push_rec.length  = len_ff;
      version_in       = version_ff;
      command_in       = command_ff;
      len_hi_in        = len_hi_ff;
      len_in           = len_ff;
      len_known_in     = len_known_ff;
      advance          = 1'b0;
      hunt             = 1'b0;
      sum_in           = sum_ff;
      pos_in           = pos_ff;
      case (pos_ff)
         hlcd_pkg::POS_HUNT: begin
            if (b == start_first_ff) begin
               sum_in = b;
               pos_in = hlcd_pkg::POS_SECOND;
            end else begin
               hunt = 1'b1;
            end
         end
         hlcd_pkg::POS_SECOND: begin
            if (b == start_second_ff) begin
               advance = 1'b1;
            end else begin
               hunt = 1'b1;
            end
         end
         hlcd_pkg::POS_VERSION: begin
            version_in = b;
            advance    = 1'b1;
         end
         hlcd_pkg::POS_COMMAND: begin
            command_in = b;
            advance    = 1'b1;
         end
         hlcd_pkg::POS_LEN_HI: begin
            len_hi_in = b;
            advance   = 1'b1;
         end
         hlcd_pkg::POS_LEN_LO: begin
            len_in       = {len_hi_ff, b};
            len_known_in = 1'b1;
            advance      = 1'b1;
         end
         default: begin
            if (len_known_ff && pos_ff == end_pos) begin
               push_rec.kind = hlcd_pkg::KIND_DONE;
               hunt          = 1'b1;
            end else if (!len_known_ff) begin
               hunt = 1'b1;
            end else begin
               push_rec.kind = hlcd_pkg::KIND_PAYLOAD;
               advance       = 1'b1;
            end
         end
      endcase
      if (advance) begin
         sum_in = sum_ff + b;
         pos_in = pos_ff + 17'd1;
      end
      if (hunt) begin
         sum_in       = '0;
         pos_in       = hlcd_pkg::POS_HUNT;
         len_known_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_first_ff  <= hlcd_pkg::START_FIRST_RESET;
         start_second_ff <= hlcd_pkg::START_SECOND_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == hlcd_pkg::CSR_START_FIRST) begin
            start_first_ff <= csr_wr_data;
         end
         if (csr_index == hlcd_pkg::CSR_START_SECOND) begin
            start_second_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= hlcd_pkg::POS_HUNT;
         sum_ff       <= '0;
         version_ff   <= '0;
         command_ff   <= '0;
         len_hi_ff    <= '0;
         len_ff       <= '0;
         len_known_ff <= 1'b0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         version_ff   <= version_in;
         command_ff   <= command_in;
         len_hi_ff    <= len_hi_in;
         len_ff       <= len_in;
         len_known_ff <= len_known_in;
      end
   end

endmodule

// ----- rtl/hlcd_queue.sv -----
// two-entry queue of classified bytes between front and back
`timescale 1ns / 1ps

module hlcd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  hlcd_pkg::rec_type push_rec,
   output logic              push_ready,
   output logic              pop_valid,
   output hlcd_pkg::rec_type pop_rec,
   input  logic              pop_ready
);

   hlcd_pkg::rec_type                  entry_ff [hlcd_pkg::QUEUE_DEPTH];
   logic [hlcd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [hlcd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [hlcd_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                               push;
   logic                               pop;

   assign push_ready = count_ff != hlcd_pkg::QUEUE_CNT_W'(hlcd_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_rec    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ----- rtl/hlcd_back.sv -----
// back end: checksum compare, result formatting and output register
`timescale 1ns / 1ps

module hlcd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  hlcd_pkg::rec_type pop_rec,
   output logic              pop_ready,
   hlcd_rsp_if.source        rsp_chan
);

   logic                          valid_ff;
   logic                          pay_valid_ff, pay_valid_in;
   logic [hlcd_pkg::BYTE_W-1:0]   pay_byte_ff, pay_byte_in;
   logic [hlcd_pkg::OFFSET_W-1:0] pay_offset_ff, pay_offset_in;
   logic                          done_ff, done_in;
   logic                          ok_ff, ok_in;
   logic [hlcd_pkg::BYTE_W-1:0]   version_ff, version_in;
   logic [hlcd_pkg::BYTE_W-1:0]   command_ff, command_in;
   logic [hlcd_pkg::LENGTH_W-1:0] length_ff, length_in;
   logic                          take;

   assign pop_ready = !valid_ff || rsp_chan.ready;
   assign take      = pop_valid && pop_ready;

   always_comb begin
      pay_valid_in  = 1'b0;
      pay_byte_in   = '0;
      pay_offset_in = '0;
      done_in       = 1'b0;
      ok_in         = 1'b0;
      version_in    = '0;
      command_in    = '0;
      length_in     = '0;
      case (pop_rec.kind)
         hlcd_pkg::KIND_PAYLOAD: begin
            pay_valid_in  = 1'b1;
            pay_byte_in   = pop_rec.data;
            pay_offset_in = pop_rec.offset;
         end
         hlcd_pkg::KIND_DONE: begin
            done_in    = 1'b1;
            ok_in      = pop_rec.data == pop_rec.sum;
            version_in = pop_rec.version;
            command_in = pop_rec.command;
            length_in  = pop_rec.length;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pay_valid_ff  <= pay_valid_in;
         pay_byte_ff   <= pay_byte_in;
         pay_offset_ff <= pay_offset_in;
         done_ff       <= done_in;
         ok_ff         <= ok_in;
         version_ff    <= version_in;
         command_ff    <= command_in;
         length_ff     <= length_in;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.payload_valid  = pay_valid_ff;
   assign rsp_chan.payload_byte   = pay_byte_ff;
   assign rsp_chan.payload_offset = pay_offset_ff;
   assign rsp_chan.frame_done     = done_ff;
   assign rsp_chan.checksum_ok    = ok_ff;
   assign rsp_chan.frame_version  = version_ff;
   assign rsp_chan.frame_command  = command_ff;
   assign rsp_chan.frame_length   = length_ff;

endmodule

// ----- rtl/header_length_checksum_deframer.sv -----
// top level of the serial frame receiver: one result transaction per byte
// a byte's result is registered in a queue entry and then in the output register
// throughput: one byte per cycle while the result side is ready, set by the combinational front classifier
// the two-entry queue and output register let input and output stall apart
// reset is synchronous and active high; start bytes return to 0x55 and 0xaa
`timescale 1ns / 1ps

module header_length_checksum_deframer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [hlcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hlcd_pkg::BYTE_W-1:0]      csr_wr_data,
   hlcd_req_if.sink                         req_chan,
   hlcd_rsp_if.source                       rsp_chan
);

   logic              push_valid;
   logic              push_ready;
   hlcd_pkg::rec_type push_rec;
   logic              pop_valid;
   logic              pop_ready;
   hlcd_pkg::rec_type pop_rec;

   hlcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_rec    (push_rec)
   );

   hlcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_rec    (pop_rec),
      .pop_ready  (pop_ready)
   );

   hlcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_rec   (pop_rec),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- sim/hlcd_frame_checker.sv -----
// checker for the frame receiver: predicts each result transaction and compares it
`timescale 1ns / 1ps

module hlcd_frame_checker
   import hlcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wr_data,
   hlcd_req_if                    req_mon,
   hlcd_rsp_if                    rsp_mon,
   output int unsigned            pending,
   output int unsigned            fail_count,
   output int unsigned            result_count,
   output int unsigned            frame_count,
   output int unsigned            good_count,
   output int unsigned            payload_count
);

   typedef struct packed {
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic [OFFSET_W-1:0] payload_offset;
      logic                frame_done;
      logic                checksum_ok;
      logic [BYTE_W-1:0]   frame_version;
      logic [BYTE_W-1:0]   frame_command;
      logic [LENGTH_W-1:0] frame_length;
   } deframe_out_type;

   logic [BYTE_W-1:0]   want_first;
   logic [BYTE_W-1:0]   want_second;
   logic [POS_W-1:0]    frame_pos;
   logic [BYTE_W-1:0]   sum_acc;
   logic [BYTE_W-1:0]   ver_q;
   logic [BYTE_W-1:0]   cmd_q;
   logic [BYTE_W-1:0]   len_hi_q;
   logic [LENGTH_W-1:0] len_q;
   logic                len_known;

   int unsigned errors      = 0;
   int unsigned results     = 0;
   int unsigned frames      = 0;
   int unsigned good_frames = 0;
   int unsigned payloads    = 0;

   deframe_out_type frame_out_q[$];

   function automatic void restart_hunt();
      frame_pos = POS_HUNT;
      sum_acc   = '0;
      len_known = 1'b0;
   endfunction

   function automatic deframe_out_type take_byte(input logic [BYTE_W-1:0] b);
      deframe_out_type  r;
      logic             advance;
      logic [POS_W-1:0] off;
      r       = '0;
      advance = 1'b1;
      case (frame_pos)
         POS_HUNT: begin
            advance = 1'b0;
            if (b == want_first) begin
               sum_acc   = b;
               frame_pos = POS_SECOND;
            end else begin
               restart_hunt();
            end
         end
         POS_SECOND: begin
            advance = 1'b0;
            if (b == want_second) begin
               sum_acc   = sum_acc + b;
               frame_pos = POS_VERSION;
            end else begin
               restart_hunt();
            end
         end
         POS_VERSION: ver_q = b;
         POS_COMMAND: cmd_q = b;
         POS_LEN_HI:  len_hi_q = b;
         POS_LEN_LO: begin
            len_q     = {len_hi_q, b};
            len_known = 1'b1;
         end
         default: begin
            if (len_known && frame_pos == HEADER_BYTES + {1'b0, len_q}) begin
               r.frame_done    = 1'b1;
               r.checksum_ok   = (b == sum_acc);
               r.frame_version = ver_q;
               r.frame_command = cmd_q;
               r.frame_length  = len_q;
               advance         = 1'b0;
               restart_hunt();
            end else if (!len_known) begin
               advance = 1'b0;
               restart_hunt();
            end else begin
               off              = frame_pos - HEADER_BYTES;
               r.payload_valid  = 1'b1;
               r.payload_byte   = b;
               r.payload_offset = off[OFFSET_W-1:0];
            end
         end
      endcase
      if (advance) begin
         sum_acc   = sum_acc + b;
         frame_pos = frame_pos + 1'b1;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, got);
      if (want !== got) begin
         errors++;
         if (errors <= 200) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      deframe_out_type want;
      if (reset) begin
         want_first  = START_FIRST_RESET;
         want_second = START_SECOND_RESET;
         restart_hunt();
         ver_q    = '0;
         cmd_q    = '0;
         len_hi_q = '0;
         len_q    = '0;
         frame_out_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            frame_out_q.push_back(take_byte(req_mon.rx_byte));
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_FIRST:  want_first = csr_wr_data;
               CSR_START_SECOND: want_second = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            results++;
            if (frame_out_q.size() == 0) begin
               errors++;
               $display("%0t: result transaction with nothing expected", $time);
            end else begin
               want = frame_out_q.pop_front();
               check_field("payload_valid", 16'(want.payload_valid),
                           16'(rsp_mon.payload_valid));
               check_field("payload_byte", 16'(want.payload_byte),
                           16'(rsp_mon.payload_byte));
               check_field("payload_offset", want.payload_offset, rsp_mon.payload_offset);
               check_field("frame_done", 16'(want.frame_done), 16'(rsp_mon.frame_done));
               check_field("checksum_ok", 16'(want.checksum_ok), 16'(rsp_mon.checksum_ok));
               check_field("frame_version", 16'(want.frame_version),
                           16'(rsp_mon.frame_version));
               check_field("frame_command", 16'(want.frame_command),
                           16'(rsp_mon.frame_command));
               check_field("frame_length", want.frame_length, rsp_mon.frame_length);
               if (want.frame_done) begin
                  frames++;
                  if (want.checksum_ok) begin
                     good_frames++;
                  end
               end
               if (want.payload_valid) begin
                  payloads++;
               end
            end
         end
      end
      pending       <= frame_out_q.size();
      fail_count    <= errors;
      result_count  <= results;
      frame_count   <= frames;
      good_count    <= good_frames;
      payload_count <= payloads;
   end

endmodule

// ----- sim/tb_header_length_checksum_deframer.sv -----
// testbench top for the frame receiver: byte stimulus, start-byte settings and verdict
`timescale 1ns / 1ps

module tb_header_length_checksum_deframer;
   import hlcd_pkg::*;

   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BEAT} sink_mode_type;

   localparam int unsigned PHASES      = 5;
   localparam int unsigned PHASE_ITEMS = 305;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]      csr_wr_data;

   int unsigned pending;
   int unsigned fail_count;
   int unsigned result_count;
   int unsigned frame_count;
   int unsigned good_count;
   int unsigned payload_count;

   hlcd_req_if req_chan ();
   hlcd_rsp_if rsp_chan ();

   logic [BYTE_W-1:0] cur_first;
   logic [BYTE_W-1:0] cur_second;
   logic [BYTE_W-1:0] tx_q[$];
   int unsigned       burst_left = 0;

   logic [BYTE_W-1:0] first_set  [PHASES] = '{8'h00, 8'hFF, 8'h00, 8'h7E, 8'h55};
   logic [BYTE_W-1:0] second_set [PHASES] = '{8'hFF, 8'h00, 8'h00, 8'h7E, 8'hAA};

   sink_mode_type sink_mode = SINK_OPEN;
   int unsigned   sink_left = 0;
   int unsigned   beat      = 0;

   header_length_checksum_deframer DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   hlcd_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .pending       (pending),
      .fail_count    (fail_count),
      .result_count  (result_count),
      .frame_count   (frame_count),
      .good_count    (good_count),
      .payload_count (payload_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_header_length_checksum_deframer NOT OK");
      $finish;
   end

   // result side stalls on its own changing pattern
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = $urandom_range(16, 160);
      end else begin
         sink_left--;
      end
      beat++;
      case (sink_mode)
         SINK_OPEN:   rsp_chan.ready <= 1'b1;
         SINK_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
         default:     rsp_chan.ready <= (beat % 3 != 0);
      endcase
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic flush_tx();
      while (tx_q.size() != 0) begin
         send_byte(tx_q.pop_front());
      end
   endtask

   task automatic queue_frame(input logic [BYTE_W-1:0] ver, cmd, input logic [15:0] len,
                              input bit sum_good);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      int                i;
      sum = cur_first + cur_second + ver + cmd + len[15:8] + len[7:0];
      tx_q.push_back(cur_first);
      tx_q.push_back(cur_second);
      tx_q.push_back(ver);
      tx_q.push_back(cmd);
      tx_q.push_back(len[15:8]);
      tx_q.push_back(len[7:0]);
      for (i = 0; i < int'(len); i++) begin
         b   = 8'($urandom);
         sum = sum + b;
         tx_q.push_back(b);
      end
      tx_q.push_back(sum_good ? sum : sum ^ 8'($urandom_range(1, 255)));
   endtask

   // block is idle once every result is back and the pipeline has emptied
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_starts(input logic [BYTE_W-1:0] first, second);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_START_FIRST;
      csr_wr_data <= first;
      @(posedge clock);
      csr_index   <= CSR_START_SECOND;
      csr_wr_data <= second;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_first  = first;
      cur_second = second;
   endtask

   initial begin
      int unsigned       p;
      int unsigned       phase_items;
      int unsigned       pick;
      int unsigned       n;
      logic [15:0]       len;
      logic [BYTE_W-1:0] b;

      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_START_FIRST;
      csr_wr_data      <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      cur_first  = START_FIRST_RESET;
      cur_second = START_SECOND_RESET;
      first_set[2]  = 8'($urandom);
      second_set[2] = 8'($urandom);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty frame, extreme header bytes
      queue_frame(8'h00, 8'hFF, 16'd0, 1'b1);
      // a failed second start byte is not taken as a new first one
      tx_q.push_back(cur_first);
      tx_q.push_back(cur_first);
      tx_q.push_back(cur_second);
      queue_frame(8'hFF, 8'h00, 16'd2, 1'b0);
      tx_q.push_back(8'hAA);
      tx_q.push_back(8'h00);
      tx_q.push_back(8'hFF);
      // leave a frame open across the start byte change
      tx_q.push_back(cur_first);
      flush_tx();

      for (p = 0; p < PHASES; p++) begin
         drain();
         write_starts(first_set[p], second_set[p]);
         phase_items = 0;
         if (p == 2) begin
            queue_frame(8'($urandom), 8'($urandom), 16'($urandom_range(256, 300)), 1'b1);
         end
         while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               len = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 6))
                                                  : 16'($urandom_range(7, 40));
               queue_frame(8'($urandom), 8'($urandom), len, $urandom_range(0, 4) != 0);
            end else if (pick < 87) begin
               tx_q.push_back(cur_first);
               tx_q.push_back(cur_second ^ 8'($urandom_range(1, 255)));
            end else begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  b = 8'($urandom);
                  if (b == cur_first) begin
                     b = b ^ 8'h01;
                  end
                  tx_q.push_back(b);
               end
            end
            phase_items += tx_q.size();
            flush_tx();
         end
      end
      drain();

      $display("covered %0d byte transactions over %0d start byte settings", result_count,
               PHASES + 1);
      $display("%0d frames closed (%0d with a good checksum), %0d payload bytes passed",
               frame_count, good_count, payload_count);
      if (fail_count == 0) begin
         $display("tb_header_length_checksum_deframer OK");
      end else begin
         $display("tb_header_length_checksum_deframer NOT OK");
      end
      $finish;
   end

endmodule
